/* design/hdr_pkg.sv */
package hdr_pkg;

   // Action codes carried in the action field of a request word.
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_READ = 1'b1;

   typedef struct packed {
      logic        action;
      logic        first;
      logic [63:0] key;
      logic [7:0]  entry;
   } hdr_req_type;

   typedef struct packed {
      logic [7:0] rank;
      logic [8:0] distinct_count;
      logic       error;
   } hdr_rsp_type;

   // Commands broadcast to every cell of the sorted chain.
   typedef struct packed {
      logic clear;
      logic insert;
      logic compare;
   } hdr_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_FETCH,
      ST_FINISH
   } hdr_state_type;

endpackage

/* design/hdr_ram.sv */
module hdr_ram
   #(parameter int WIDTH = 64,
     parameter int DEPTH = 256)
   (input  logic                     clock,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/hdr_cell.sv */
module hdr_cell
   import hdr_pkg::*;
   #(parameter int KEY_W = 64)
   (input  logic             clock,
    input  logic             reset,
    input  hdr_ctl_type      ctl,
    input  logic [KEY_W-1:0] bcast_key,
    input  logic [KEY_W-1:0] left_key,
    input  logic             left_valid,
    input  logic             left_lt,
    output logic [KEY_W-1:0] key_out,
    output logic             valid_out,
    output logic             lt_out,
    output logic             eq_out);

   logic [KEY_W-1:0] key_ff, key_in;
   logic             valid_ff, valid_in;

   // An empty cell behaves as if it held a key above every other key.
   assign lt_out    = !valid_ff || (bcast_key < key_ff);
   assign eq_out    = valid_ff && (bcast_key == key_ff);
   assign key_out   = key_ff;
   assign valid_out = valid_ff;

   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.insert && lt_out) begin
         if (left_lt) begin
            key_in   = left_key;
            valid_in = left_valid;
         end else begin
            key_in   = bcast_key;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff <= key_in;
   end

endmodule

/* design/hdr_chain.sv */
module hdr_chain
   import hdr_pkg::*;
   #(parameter int MAX_HAPS = 256,
     parameter int KEY_W    = 64)
   (input  logic                            clock,
    input  logic                            reset,
    input  hdr_ctl_type                     ctl,
    input  logic [KEY_W-1:0]                bcast_key,
    output logic [$clog2(MAX_HAPS+1)-1:0]   total,
    output logic [$clog2(MAX_HAPS+1)-1:0]   rank);

   localparam int CW = $clog2(MAX_HAPS + 1);

   logic [KEY_W-1:0]    cell_key [MAX_HAPS];
   logic [MAX_HAPS-1:0] cell_valid, cell_lt, cell_eq;
   logic [MAX_HAPS-1:0] below, below_ff, below_in, below_next, last;
   logic [CW-1:0]       total_ff, total_in;
   logic                do_insert;
   hdr_ctl_type         cell_ctl;

   // A key already present, or a full list, leaves the chain untouched.
   assign do_insert = ctl.insert && !(|cell_eq) && !cell_valid[MAX_HAPS-1];

   always_comb begin
      cell_ctl        = ctl;
      cell_ctl.insert = do_insert;
   end

   for (genvar i = 0; i < MAX_HAPS; i++) begin : g_cell
      if (i == 0) begin : g_head
         hdr_cell #(.KEY_W(KEY_W)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (cell_ctl),
            .bcast_key  (bcast_key),
            .left_key   (bcast_key),
            .left_valid (1'b0),
            .left_lt    (1'b0),
            .key_out    (cell_key[i]),
            .valid_out  (cell_valid[i]),
            .lt_out     (cell_lt[i]),
            .eq_out     (cell_eq[i]));
      end else begin : g_body
         hdr_cell #(.KEY_W(KEY_W)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (cell_ctl),
            .bcast_key  (bcast_key),
            .left_key   (cell_key[i-1]),
            .left_valid (cell_valid[i-1]),
            .left_lt    (cell_lt[i-1]),
            .key_out    (cell_key[i]),
            .valid_out  (cell_valid[i]),
            .lt_out     (cell_lt[i]),
            .eq_out     (cell_eq[i]));
      end
   end

   // Cells holding a key below the probe form a run starting at cell zero.
   assign below      = cell_valid & ~cell_lt & ~cell_eq;
   assign below_next = {1'b0, below_ff[MAX_HAPS-1:1]};
   assign last       = below_ff & ~below_next;

   always_comb begin
      rank = '0;
      for (int i = 0; i < MAX_HAPS; i++) begin
         if (last[i]) begin
            rank = rank | CW'(i + 1);
         end
      end
   end

   always_comb begin
      below_in = ctl.compare ? below : below_ff;
      total_in = total_ff;
      if (ctl.clear) begin
         total_in = '0;
      end else if (do_insert) begin
         total_in = total_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
      below_ff <= below_in;
   end

   assign total = total_ff;

endmodule

/* design/haplotype_dense_rank_unit.sv */
// Loads are accepted with a RAM write, then take one insertion step in the sorted cell chain.
// Reads reach the response register through RAM fetch, broadcast compare and rank encode.
// An erroring word (overflowed load or unloaded entry) skips the RAM and chain and goes straight to the response stage.
// One word is in flight at a time; a finished response may wait while the next word is taken.
// Synchronous active-high reset empties the window; the key RAM itself is not cleared.
module haplotype_dense_rank_unit
   import hdr_pkg::*;
   #(parameter int MAX_HAPS    = 256,
     parameter int WINDOW_SNPS = 16)
   (input  logic        clock,
    input  logic        reset,
    input  logic        req_valid,
    output logic        req_ready,
    input  hdr_req_type req_data,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output hdr_rsp_type rsp_data);

   localparam int KEY_W = 4 * WINDOW_SNPS;
   localparam int CW    = $clog2(MAX_HAPS + 1);
   localparam int AW    = $clog2(MAX_HAPS);
   localparam int EW    = (CW > 8) ? CW : 8;

   hdr_state_type state_ff, state_in;

   logic [CW-1:0]    count_ff, count_in, base_count;
   logic             overflow_ff, overflow_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic             err_ff, err_in;
   logic             zero_ff, zero_in;
   logic             rsp_valid_ff, rsp_valid_in;
   hdr_rsp_type      rsp_data_ff, rsp_data_in;

   logic             accept, is_load, load_full, read_bad;
   logic             ram_we;
   logic [AW-1:0]    ram_addr;
   logic [KEY_W-1:0] ram_rdata, bcast_key;
   logic [CW-1:0]    chain_total, chain_rank;
   hdr_ctl_type      ctl;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_load   = (req_data.action == ACT_LOAD);

   // A first word restarts the window, so capacity is judged from zero.
   assign base_count = req_data.first ? '0 : count_ff;
   assign load_full  = (base_count >= CW'(MAX_HAPS));
   assign read_bad   = (EW'(req_data.entry) >= EW'(count_ff));

   // Stored keys never include bits above the window's SNP span.
   assign bcast_key = (state_ff == ST_INSERT) ? key_ff : ram_rdata;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      key_in       = key_ff;
      err_in       = err_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      ctl          = '0;
      ram_we       = 1'b0;
      ram_addr     = EW'(req_data.entry) >= EW'(1 << AW) ? '0 : AW'(EW'(req_data.entry));

      case (state_ff)
         ST_IDLE: begin
            if (accept && is_load) begin
               ram_addr = AW'(base_count);
               if (req_data.first) begin
                  ctl.clear   = 1'b1;
                  overflow_in = 1'b0;
               end
               if (load_full) begin
                  overflow_in = 1'b1;
                  err_in      = 1'b1;
                  zero_in     = 1'b1;
                  state_in    = ST_FINISH;
               end else begin
                  ram_we   = 1'b1;
                  count_in = base_count + CW'(1);
                  key_in   = req_data.key[KEY_W-1:0];
                  state_in = ST_INSERT;
               end
            end else if (accept) begin
               if (read_bad) begin
                  err_in   = 1'b1;
                  zero_in  = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  err_in   = overflow_ff;
                  zero_in  = 1'b0;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_INSERT: begin
            ctl.insert = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_FETCH: begin
            // The entry's key is out of the RAM now; probe the whole chain with it.
            ctl.compare = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.rank           = zero_ff ? '0 : 8'(chain_rank);
               rsp_data_in.distinct_count = 9'(chain_total);
               rsp_data_in.error          = err_ff;
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff      <= key_in;
      err_ff      <= err_in;
      zero_ff     <= zero_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   hdr_ram #(.WIDTH(KEY_W), .DEPTH(MAX_HAPS)) u_keys (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (req_data.key[KEY_W-1:0]),
      .rd_data (ram_rdata));

   hdr_chain #(.MAX_HAPS(MAX_HAPS), .KEY_W(KEY_W)) u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .bcast_key (bcast_key),
      .total     (chain_total),
      .rank      (chain_rank));

`ifndef ASSERT_OFF
   a_distinct_le_count: assert property (@(posedge clock) disable iff (reset)
      chain_total <= count_ff)
      else $error("distinct total exceeds loaded entry count");

   a_count_le_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_HAPS))
      else $error("entry count exceeds capacity");

   a_rank_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !zero_ff) |-> (chain_rank < chain_total))
      else $error("rank of a loaded entry not below distinct total");

   a_insert_after_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSERT) |-> $past(accept && is_load && !load_full))
      else $error("insert step without an accepted load");
`endif

endmodule
